@@ hdl/olad_pkg.sv @@
// Shared types and codes for the ordered list block.
// No dependencies; imported by every module under hdl/.
package olad_pkg;

  localparam int DataW = 32;

  // Operation selector on the input channel
  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } olad_func_e;

  // Status codes on the result channel
  typedef enum logic [2:0] {
    STAT_APPENDED = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_DELETED  = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_EMPTY    = 3'd4
  } olad_status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_READ
  } olad_state_e;

  // What each cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,    // keep value
    CELL_LOAD,    // selected cell takes data, others hold
    CELL_ROTATE,  // selected cell takes data, others take their neighbor
    CELL_SHIFT    // every cell takes its neighbor
  } olad_cell_op_e;

  typedef struct packed {
    olad_cell_op_e           op;
    logic [DataW-1:0]        data;
  } olad_cell_ctl_t;

endpackage

@@ hdl/olad_cell.sv @@
// One list cell: holds a single entry and takes its upper neighbor on shifts.
// Depends on olad_pkg.
module olad_cell import olad_pkg::*; #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                clk_i,
  input  olad_cell_ctl_t      ctl_i,
  input  logic [IW-1:0]       sel_i,
  input  logic [DataW-1:0]    nbr_i,
  output logic [DataW-1:0]    val_o
);

  logic [DataW-1:0] val_q, val_d;
  logic             hit;

  assign hit = (sel_i == IW'(IDX));

  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      CELL_LOAD:   if (hit) val_d = ctl_i.data;
      CELL_ROTATE: val_d = hit ? ctl_i.data : nbr_i;
      CELL_SHIFT:  val_d = nbr_i;
      default:     val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

@@ hdl/olad_ctrl.sv @@
// Sequencer for the ordered list: count, rotation length, step counter,
// cell control and the registered result stage. Depends on olad_pkg.
module olad_ctrl import olad_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int IW       = 4,
  parameter int CW       = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               func_i,
  input  logic signed [DataW-1:0]  value_i,
  input  logic [DataW-1:0]         head_i,
  output olad_cell_ctl_t           ctl_o,
  output logic [IW-1:0]            sel_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic                     is_element_o,
  output logic signed [DataW-1:0]  element_o,
  output logic                     last_o
);

  olad_state_e       state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     len_q, len_d;
  logic [CW-1:0]     step_q, step_d;
  logic              found_q, found_d;
  logic [DataW-1:0]  key_q, key_d;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        status_q, status_d;
  logic              is_el_q, is_el_d;
  logic [DataW-1:0]  elem_q, elem_d;
  logic              last_q, last_d;

  logic              out_ok, accept, last_step, match;
  logic [CW-1:0]     count_m1, len_m1;

  assign out_ok     = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_ok;
  assign accept     = in_valid_i && !in_stall_o;
  assign count_m1   = count_q - CW'(1);
  assign len_m1     = len_q - CW'(1);
  assign last_step  = (step_q == count_m1);
  assign match      = !found_q && (head_i == key_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && count_q != '0) begin
          if (func_i == FUNC_DELETE) state_d = S_DEL;
          else if (func_i == FUNC_READ) state_d = S_READ;
        end
      end
      S_DEL, S_READ: begin
        if (out_ok && last_step) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    len_d       = len_q;
    step_d      = step_q;
    found_d     = found_q;
    key_d       = key_q;
    ctl_o.op    = CELL_HOLD;
    ctl_o.data  = head_i;
    sel_o       = len_m1[IW-1:0];
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    is_el_d     = is_el_q;
    elem_d      = elem_q;
    last_d      = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          is_el_d = 1'b0;
          elem_d  = '0;
          last_d  = 1'b1;
          step_d  = '0;
          found_d = 1'b0;
          len_d   = count_q;
          key_d   = value_i;
          case (func_i)
            FUNC_APPEND: begin
              out_valid_d = 1'b1;
              if (count_q == CW'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else begin
                ctl_o.op   = CELL_LOAD;
                ctl_o.data = value_i;
                sel_o      = count_q[IW-1:0];
                count_d    = count_q + CW'(1);
                status_d   = STAT_APPENDED;
              end
            end
            FUNC_DELETE: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                status_d    = STAT_NOTFOUND;
              end
            end
            FUNC_READ: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                status_d    = STAT_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEL: begin
        if (out_ok) begin
          step_d = step_q + CW'(1);
          if (match) begin
            // drop the head and shorten the ring
            ctl_o.op = CELL_SHIFT;
            len_d    = len_m1;
            found_d  = 1'b1;
          end else begin
            ctl_o.op = CELL_ROTATE;
          end
          if (last_step) begin
            count_d     = match ? len_m1 : len_q;
            out_valid_d = 1'b1;
            status_d    = (found_q || match) ? STAT_DELETED : STAT_NOTFOUND;
            is_el_d     = 1'b0;
            elem_d      = '0;
            last_d      = 1'b1;
          end
        end
      end
      S_READ: begin
        if (out_ok) begin
          ctl_o.op    = CELL_ROTATE;
          step_d      = step_q + CW'(1);
          out_valid_d = 1'b1;
          status_d    = STAT_APPENDED;  // zero on element results
          is_el_d     = 1'b1;
          elem_d      = head_i;
          last_d      = last_step;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    step_q   <= step_d;
    found_q  <= found_d;
    key_q    <= key_d;
    status_q <= status_d;
    is_el_q  <= is_el_d;
    elem_q   <= elem_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign is_element_o = is_el_q;
  assign element_o    = elem_q;
  assign last_o       = last_q;

endmodule

@@ hdl/ordered_list_append_delete.sv @@
// Ordered list of signed words: append at tail, delete first match, read out.
// Top level; instantiates olad_ctrl and a row of olad_cell. Uses olad_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o, func_i, value_i) takes one item
//   when valid is high and stall is low. Output channel (out_valid_o /
//   out_stall_i) delivers results from a single output register.
//   Append: one result (appended or full), registered in the cycle after accept.
//   Delete: the list rotates through a chain of cells, one entry per cycle
//     while the output is not stalled; the first matching head is dropped on
//     the way and the ring closes up. Empty list answers not found.
//   Read out: count results, one per cycle while the output is not stalled,
//     the last one marked; an empty list gives one result, status list empty.
//   An item is taken only when the sequencer is idle; a delete or read out
//   holds the input stalled until its pass is done, as does an output stall.
//   When the receiver stalls, the chain and the step counter freeze and the
//   pending result holds.
//   Reset clears the count and the sequencer; entry contents are left as is
//   and are never read before they are written.
module ordered_list_append_delete import olad_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               func_i,
  input  logic signed [DataW-1:0]  value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic                     is_element_o,
  output logic signed [DataW-1:0]  element_o,
  output logic                     last_o
);

  localparam int IW = $clog2(CAPACITY);      // cell index width
  localparam int CW = $clog2(CAPACITY + 1);  // count width

  olad_cell_ctl_t    cell_ctl;
  logic [IW-1:0]     cell_sel;
  logic [DataW-1:0]  cell_val [CAPACITY];

  olad_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .head_i       (cell_val[0]),
    .ctl_o        (cell_ctl),
    .sel_o        (cell_sel),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .is_element_o (is_element_o),
    .element_o    (element_o),
    .last_o       (last_o)
  );

  // Chain of cells: cell i takes cell i+1 on a shift; the head sits in cell 0.
  // The top cell's neighbor is the head, which closes the ring.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_top
      assign nbr = cell_val[0];
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end
    olad_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk_i (clk_i),
      .ctl_i (cell_ctl),
      .sel_i (cell_sel),
      .nbr_i (nbr),
      .val_o (cell_val[i])
    );
  end

endmodule
